// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Synthesis builds define SYNTHESIS and
// get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked property, disabled while reset is asserted (active low).
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed: label");

// Condition that must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("assertion failed: label");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ===== hw/rtl/rqf_pkg.sv =====
`default_nettype none

package rqf_pkg;

    // Build-time limits
    localparam int MAX_READ_LEN = 65535;
    localparam bit CHECK_IUPAC  = 1'b1;

    // Field widths
    localparam int CNT_W   = 16;
    localparam int QOFF_W  = 7;
    localparam int SCORE_W = 9;
    localparam int SUM_W   = 25;
    localparam int PROD_W  = 24;

    // Length counter stops here (never above the 16-bit field)
    localparam logic [CNT_W-1:0] LEN_CAP =
        (MAX_READ_LEN < 65535) ? CNT_W'(MAX_READ_LEN) : 16'hFFFF;

    localparam logic signed [SCORE_W-1:0] MIN_SCORE_INIT = 9'sd255;
    localparam logic signed [SUM_W-1:0]   SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0]   SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [6:0]                GC_SCALE = 7'd100;

    // Base characters
    localparam logic [7:0] CH_A_UP = 8'h41;
    localparam logic [7:0] CH_C_UP = 8'h43;
    localparam logic [7:0] CH_G_UP = 8'h47;
    localparam logic [7:0] CH_N_UP = 8'h4E;
    localparam logic [7:0] CH_T_UP = 8'h54;
    localparam logic [7:0] CH_A_LO = 8'h61;
    localparam logic [7:0] CH_C_LO = 8'h63;
    localparam logic [7:0] CH_G_LO = 8'h67;
    localparam logic [7:0] CH_N_LO = 8'h6E;
    localparam logic [7:0] CH_T_LO = 8'h74;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_QUAL_OFFSET    = 3'd0,
        CFG_MAX_N_COUNT    = 3'd1,
        CFG_MIN_BASE_QUAL  = 3'd2,
        CFG_MIN_MEAN_QUAL  = 3'd3,
        CFG_MIN_LENGTH     = 3'd4,
        CFG_MAX_LENGTH     = 3'd5,
        CFG_MIN_GC_PERCENT = 3'd6,
        CFG_MAX_GC_PERCENT = 3'd7
    } t_cfg_idx;

    // Fail mask bit positions
    localparam int FAIL_N_COUNT   = 0;
    localparam int FAIL_BASE_QUAL = 1;
    localparam int FAIL_MEAN_QUAL = 2;
    localparam int FAIL_MIN_LEN   = 3;
    localparam int FAIL_MAX_LEN   = 4;
    localparam int FAIL_MAX_GC    = 5;
    localparam int FAIL_MIN_GC    = 6;
    localparam int FAIL_IUPAC     = 7;

    typedef struct packed {
        logic is_n;
        logic is_gc;
        logic is_at;
    } t_base_class;

    function automatic t_base_class classify(input logic [7:0] ch);
        t_base_class c;
        c.is_n  = (ch == CH_N_UP) || (ch == CH_N_LO);
        c.is_gc = (ch == CH_G_UP) || (ch == CH_C_UP) || (ch == CH_G_LO) ||
                  (ch == CH_C_LO);
        c.is_at = (ch == CH_A_UP) || (ch == CH_T_UP) || (ch == CH_A_LO) ||
                  (ch == CH_T_LO);
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/read_quality_filter_unit.sv =====
// Read quality filter. One sequencing read streams in as one word per base
// (base character in tdata[7:0], quality character in tdata[15:8], tlast on
// the final base). The unit takes one base per clock unless stalled. For each read it emits
// exactly one result word. The word goes valid once the last base has passed
// through the snapshot register and then the result register.
// It carries the pass flag, the mask of failed filters and the length, N, G/C
// and lowest-score figures. Bases past 65535 are not counted (length, N, GC
// and score sum hold) but still feed the lowest score and the odd-base check.
// Input backpressure only appears when a final base sits in the input register
// while the snapshot register and a stalled result word both hold finished
// reads. Non-final bases ahead of it always flow. Configuration registers are
// written through the cfg channel (always ready) and should only change
// between reads.
`default_nettype none
`include "assert_macros.svh"

module read_quality_filter_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    // Base stream in
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [7:0] base_char, [15:8] qual_char
    input  wire logic        s_axis_tlast,
    // Read result out
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [0] passed, [8:1] fail_mask, [24:9] read_length, [40:25] n_total,
    // [56:41] gc_total, [65:57] lowest_score, [71:66] zero
    output logic [71:0]      m_axis_tdata
);

    localparam int CW = rqf_pkg::CNT_W;
    localparam int SW = rqf_pkg::SUM_W;
    localparam int QW = rqf_pkg::SCORE_W;
    localparam int PW = rqf_pkg::PROD_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [6:0]    r_qual_offset;
    logic [CW-1:0] r_max_n_count;
    logic [6:0]    r_min_base_qual;
    logic [6:0]    r_min_mean_qual;
    logic [CW-1:0] r_min_length;
    logic [CW-1:0] r_max_length;
    logic [6:0]    r_min_gc_percent;
    logic [6:0]    r_max_gc_percent;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qual_offset    <= 7'd33;
            r_max_n_count    <= 16'hFFFF;
            r_min_base_qual  <= 7'd0;
            r_min_mean_qual  <= 7'd0;
            r_min_length     <= 16'd0;
            r_max_length     <= 16'hFFFF;
            r_min_gc_percent <= 7'd0;
            r_max_gc_percent <= 7'd100;
        end else if (i_cfg_valid) begin
            unique case (rqf_pkg::t_cfg_idx'(i_cfg_index))
                rqf_pkg::CFG_QUAL_OFFSET:    r_qual_offset    <= i_cfg_data[6:0];
                rqf_pkg::CFG_MAX_N_COUNT:    r_max_n_count    <= i_cfg_data;
                rqf_pkg::CFG_MIN_BASE_QUAL:  r_min_base_qual  <= i_cfg_data[6:0];
                rqf_pkg::CFG_MIN_MEAN_QUAL:  r_min_mean_qual  <= i_cfg_data[6:0];
                rqf_pkg::CFG_MIN_LENGTH:     r_min_length     <= i_cfg_data;
                rqf_pkg::CFG_MAX_LENGTH:     r_max_length     <= i_cfg_data;
                rqf_pkg::CFG_MIN_GC_PERCENT: r_min_gc_percent <= i_cfg_data[6:0];
                rqf_pkg::CFG_MAX_GC_PERCENT: r_max_gc_percent <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline handshake: input reg -> accumulate/snapshot -> result reg.
    // A non-final base always drains; a final base waits for the snapshot
    // register, which waits for the result register.
    // ------------------------------------------------------------------
    logic r_in_valid, r_in_last;
    logic [7:0] r_in_base, r_in_qual;
    logic r_fin_valid;
    logic r_out_valid;

    logic out_ready, fin_ready, s1_consume, s1_ready;

    assign out_ready  = !r_out_valid || m_axis_tready;
    assign fin_ready  = !r_fin_valid || out_ready;
    assign s1_consume = r_in_valid && (!r_in_last || fin_ready);
    assign s1_ready   = !r_in_valid || s1_consume;
    assign s_axis_tready = s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s1_ready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && s_axis_tvalid) begin
            r_in_base <= s_axis_tdata[7:0];
            r_in_qual <= s_axis_tdata[15:8];
            r_in_last <= s_axis_tlast;
        end
    end

    // ------------------------------------------------------------------
    // Per-read accumulators
    // ------------------------------------------------------------------
    logic [CW-1:0]        r_base_count, r_n_count, r_gc_count;
    logic signed [SW-1:0] r_score_sum;
    logic signed [QW-1:0] r_min_score;
    logic                 r_odd_seen;

    logic [CW-1:0]        n_base_count, n_n_count, n_gc_count;
    logic signed [SW-1:0] n_score_sum;
    logic signed [QW-1:0] n_min_score;
    logic                 n_odd_seen;

    rqf_pkg::t_base_class cls;
    logic signed [QW-1:0] score;
    logic signed [SW:0]   sum_wide;

    always_comb begin
        cls   = rqf_pkg::classify(r_in_base);
        // qual 0..255 minus offset 0..127 always fits 9-bit signed
        score = $signed({1'b0, r_in_qual}) - $signed({2'b00, r_qual_offset});
        sum_wide = {r_score_sum[SW-1], r_score_sum} +
                   {{(SW+1-QW){score[QW-1]}}, score};

        n_min_score  = (score < r_min_score) ? score : r_min_score;
        n_odd_seen   = r_odd_seen || !(cls.is_n || cls.is_gc || cls.is_at);
        n_base_count = r_base_count;
        n_n_count    = r_n_count;
        n_gc_count   = r_gc_count;
        n_score_sum  = r_score_sum;
        if (r_base_count < rqf_pkg::LEN_CAP) begin
            n_base_count = r_base_count + CW'(1);
            n_n_count    = r_n_count + CW'(cls.is_n);
            n_gc_count   = r_gc_count + CW'(cls.is_gc);
            // saturate on signed overflow of the 25-bit sum
            if (sum_wide[SW] != sum_wide[SW-1]) begin
                n_score_sum = sum_wide[SW] ? rqf_pkg::SUM_MIN : rqf_pkg::SUM_MAX;
            end else begin
                n_score_sum = sum_wide[SW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_count <= '0;
            r_n_count    <= '0;
            r_gc_count   <= '0;
            r_score_sum  <= '0;
            r_min_score  <= rqf_pkg::MIN_SCORE_INIT;
            r_odd_seen   <= 1'b0;
        end else if (s1_consume) begin
            if (r_in_last) begin
                // read done: restart for the next one
                r_base_count <= '0;
                r_n_count    <= '0;
                r_gc_count   <= '0;
                r_score_sum  <= '0;
                r_min_score  <= rqf_pkg::MIN_SCORE_INIT;
                r_odd_seen   <= 1'b0;
            end else begin
                r_base_count <= n_base_count;
                r_n_count    <= n_n_count;
                r_gc_count   <= n_gc_count;
                r_score_sum  <= n_score_sum;
                r_min_score  <= n_min_score;
                r_odd_seen   <= n_odd_seen;
            end
        end
    end

    // ------------------------------------------------------------------
    // Snapshot of the finished read's totals
    // ------------------------------------------------------------------
    logic [CW-1:0]        r_fin_len, r_fin_n, r_fin_gc;
    logic signed [SW-1:0] r_fin_sum;
    logic signed [QW-1:0] r_fin_min;
    logic                 r_fin_odd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (fin_ready) begin
            r_fin_valid <= s1_consume && r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_ready && s1_consume && r_in_last) begin
            r_fin_len <= n_base_count;
            r_fin_n   <= n_n_count;
            r_fin_gc  <= n_gc_count;
            r_fin_sum <= n_score_sum;
            r_fin_min <= n_min_score;
            r_fin_odd <= n_odd_seen;
        end
    end

    // ------------------------------------------------------------------
    // Filter checks: mean and GC percent compared by cross-multiplying
    // ------------------------------------------------------------------
    logic [PW-1:0]  mean_floor, gc_hi_lim, gc_lo_lim, gc_scaled;
    logic [7:0]     fail_mask;

    always_comb begin
        // 7 x 16 bit products, at most 127 * 65535, fit in 24 bits
        mean_floor = PW'(r_min_mean_qual) * PW'(r_fin_len);
        gc_hi_lim  = PW'(r_max_gc_percent) * PW'(r_fin_len);
        gc_lo_lim  = PW'(r_min_gc_percent) * PW'(r_fin_len);
        gc_scaled  = PW'(rqf_pkg::GC_SCALE) * PW'(r_fin_gc);

        fail_mask = '0;
        fail_mask[rqf_pkg::FAIL_N_COUNT]   = r_fin_n > r_max_n_count;
        fail_mask[rqf_pkg::FAIL_BASE_QUAL] =
            $signed({r_fin_min[QW-1], r_fin_min}) < $signed({3'b000, r_min_base_qual});
        fail_mask[rqf_pkg::FAIL_MEAN_QUAL] =
            $signed({r_fin_sum[SW-1], r_fin_sum}) < $signed({2'b00, mean_floor});
        fail_mask[rqf_pkg::FAIL_MIN_LEN]   = r_fin_len < r_min_length;
        fail_mask[rqf_pkg::FAIL_MAX_LEN]   = r_fin_len > r_max_length;
        fail_mask[rqf_pkg::FAIL_MAX_GC]    = gc_hi_lim < gc_scaled;
        fail_mask[rqf_pkg::FAIL_MIN_GC]    = gc_lo_lim > gc_scaled;
        fail_mask[rqf_pkg::FAIL_IUPAC]     = rqf_pkg::CHECK_IUPAC && r_fin_odd;
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic                 r_out_passed;
    logic [7:0]           r_out_mask;
    logic [CW-1:0]        r_out_len, r_out_n, r_out_gc;
    logic signed [QW-1:0] r_out_min;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_fin_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_fin_valid) begin
            r_out_passed <= (fail_mask == 8'd0);
            r_out_mask   <= fail_mask;
            r_out_len    <= r_fin_len;
            r_out_n      <= r_fin_n;
            r_out_gc     <= r_fin_gc;
            r_out_min    <= r_fin_min;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_min, r_out_gc, r_out_n, r_out_len,
                            r_out_mask, r_out_passed};

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    logic last_stuck, last_fire, acc_idle;

    assign last_stuck = r_in_valid && r_in_last && r_fin_valid && !out_ready;
    assign last_fire  = s1_consume && r_in_last;
    assign acc_idle   = (r_base_count == '0) && (r_min_score == rqf_pkg::MIN_SCORE_INIT);

    // a final base must not slip past a full snapshot stage
    `ASSERT_PROP(a_last_held, i_clk, i_rst_n, last_stuck |=> r_in_valid)
    // accumulators restart after each read
    `ASSERT_PROP(a_read_cleared, i_clk, i_rst_n, last_fire |=> acc_idle)
    // every reported read holds at least its last base
    `ASSERT_NEVER(a_empty_read, i_clk, i_rst_n, r_out_valid && r_out_len == '0)

endmodule

`default_nettype wire

// ===== test/read_quality_filter_unit_tb.sv =====
`timescale 1ns / 1ps

module read_quality_filter_unit_tb;

    localparam int STALL_LIMIT = 3000;      // cycles with no handshake at all
    localparam int HOLD_CYCLES = 300;       // long receiver hold-off
    localparam longint SCORE_SUM_HI = 64'sd16777215;
    localparam longint SCORE_SUM_LO = -64'sd16777216;

    // one base word as the driver sends it
    typedef struct {
        logic [7:0] base;
        logic [7:0] qual;
        logic       last;
    } t_base_word;

    // result word, laid out to match m_axis_tdata bit for bit
    typedef struct packed {
        logic [5:0]  pad;
        logic [8:0]  lowest_score;
        logic [15:0] gc_total;
        logic [15:0] n_total;
        logic [15:0] read_length;
        logic [7:0]  fail_mask;
        logic        passed;
    } t_verdict;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;

    read_quality_filter_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Filter settings as the unit should hold them
    // ------------------------------------------------------------------
    logic [6:0]  qual_offset_r   = 7'd33;
    logic [15:0] max_n_r         = 16'hFFFF;
    logic [6:0]  min_base_qual_r = 7'd0;
    logic [6:0]  min_mean_qual_r = 7'd0;
    logic [15:0] min_len_r       = 16'd0;
    logic [15:0] max_len_r       = 16'hFFFF;
    logic [6:0]  min_gc_r        = 7'd0;
    logic [6:0]  max_gc_r        = 7'd100;

    // running figures of the read in progress
    logic [15:0] rd_len = '0;
    logic [15:0] rd_n   = '0;
    logic [15:0] rd_gc  = '0;
    longint      rd_sum = 0;
    int          rd_low = 255;
    bit          rd_odd = 1'b0;

    t_base_word  base_q [$];     // words waiting for the driver
    t_verdict    verdict_q [$];  // read verdicts the unit still owes us

    int  bases_queued   = 0;
    int  bases_accepted = 0;
    int  reads_checked  = 0;
    int  settings_used  = 0;
    int  fails          = 0;
    bit  word_taken     = 1'b0;
    int  send_idle_pct  = 0;
    int  recv_idle_pct  = 0;
    int  rx_hold        = 0;
    logic [15:0] plan [8];

    task automatic apply_reg(input rqf_pkg::t_cfg_idx idx, input logic [15:0] val);
        case (idx)
            rqf_pkg::CFG_QUAL_OFFSET:    qual_offset_r   = val[6:0];
            rqf_pkg::CFG_MAX_N_COUNT:    max_n_r         = val;
            rqf_pkg::CFG_MIN_BASE_QUAL:  min_base_qual_r = val[6:0];
            rqf_pkg::CFG_MIN_MEAN_QUAL:  min_mean_qual_r = val[6:0];
            rqf_pkg::CFG_MIN_LENGTH:     min_len_r       = val;
            rqf_pkg::CFG_MAX_LENGTH:     max_len_r       = val;
            rqf_pkg::CFG_MIN_GC_PERCENT: min_gc_r        = val[6:0];
            rqf_pkg::CFG_MAX_GC_PERCENT: max_gc_r        = val[6:0];
            default: ;
        endcase
    endtask

    // Fold one base into the read figures; on the last base grade the read
    // and queue the verdict.
    task automatic tally_base(input logic [7:0] b, input logic [7:0] q, input logic last);
        int       score;
        bit       is_n, is_gc, is_at;
        logic [7:0] mask;
        longint   len;
        t_verdict v;
        score = int'(q) - int'(qual_offset_r);
        is_n  = (b == "N") || (b == "n");
        is_gc = (b == "G") || (b == "C") || (b == "g") || (b == "c");
        is_at = (b == "A") || (b == "T") || (b == "a") || (b == "t");
        // lowest score and odd-base flag keep tracking past the length cap
        if (score < rd_low)
            rd_low = score;
        if (!is_n && !is_gc && !is_at)
            rd_odd = 1'b1;
        if (rd_len < rqf_pkg::LEN_CAP) begin
            rd_len++;
            if (is_n)
                rd_n++;
            if (is_gc)
                rd_gc++;
            rd_sum += score;
            if (rd_sum > SCORE_SUM_HI)
                rd_sum = SCORE_SUM_HI;
            if (rd_sum < SCORE_SUM_LO)
                rd_sum = SCORE_SUM_LO;
        end
        if (last) begin
            len  = longint'(rd_len);
            mask = '0;
            if (rd_n > max_n_r)
                mask[rqf_pkg::FAIL_N_COUNT] = 1'b1;
            if (rd_low < int'(min_base_qual_r))
                mask[rqf_pkg::FAIL_BASE_QUAL] = 1'b1;
            if (rd_sum < longint'(min_mean_qual_r) * len)
                mask[rqf_pkg::FAIL_MEAN_QUAL] = 1'b1;
            if (rd_len < min_len_r)
                mask[rqf_pkg::FAIL_MIN_LEN] = 1'b1;
            if (rd_len > max_len_r)
                mask[rqf_pkg::FAIL_MAX_LEN] = 1'b1;
            // GC percent bounds, cross-multiplied
            if (longint'(max_gc_r) * len < 100 * longint'(rd_gc))
                mask[rqf_pkg::FAIL_MAX_GC] = 1'b1;
            if (longint'(min_gc_r) * len > 100 * longint'(rd_gc))
                mask[rqf_pkg::FAIL_MIN_GC] = 1'b1;
            if (rqf_pkg::CHECK_IUPAC && rd_odd)
                mask[rqf_pkg::FAIL_IUPAC] = 1'b1;
            v.pad          = '0;
            v.passed       = (mask == '0);
            v.fail_mask    = mask;
            v.read_length  = rd_len;
            v.n_total      = rd_n;
            v.gc_total     = rd_gc;
            v.lowest_score = 9'(rd_low);
            verdict_q = {verdict_q, v};
            rd_len = '0;
            rd_n   = '0;
            rd_gc  = '0;
            rd_sum = 0;
            rd_low = 255;
            rd_odd = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: config writes, result words and accepted bases, all sampled
    // at the rising edge. Results are handled before new bases.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_verdict got, want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                apply_reg(rqf_pkg::t_cfg_idx'(i_cfg_index), i_cfg_data);
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (verdict_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result word %h", m_axis_tdata);
                end else begin
                    want = verdict_q.pop_front();
                    if (got.passed !== want.passed || got.fail_mask !== want.fail_mask ||
                        got.read_length !== want.read_length ||
                        got.n_total !== want.n_total || got.gc_total !== want.gc_total ||
                        got.lowest_score !== want.lowest_score || got.pad !== want.pad) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("read %0d mismatch at %0t", reads_checked, $realtime);
                            $display("  exp pass=%b mask=%h len=%0d n=%0d gc=%0d low=%0d pad=%h",
                                     want.passed, want.fail_mask, want.read_length,
                                     want.n_total, want.gc_total,
                                     $signed(want.lowest_score), want.pad);
                            $display("  got pass=%b mask=%h len=%0d n=%0d gc=%0d low=%0d pad=%h",
                                     got.passed, got.fail_mask, got.read_length,
                                     got.n_total, got.gc_total,
                                     $signed(got.lowest_score), got.pad);
                        end
                    end
                    reads_checked++;
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                word_taken = 1'b1;
                bases_accepted++;
                tally_base(s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tlast);
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: holds a word until taken, then maybe idles, then offers the
    // next one from base_q. Changes only at the falling edge.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_base_word w;
        if (!s_axis_tvalid || word_taken) begin
            word_taken = 1'b0;
            if (base_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                w = base_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {w.qual, w.base};
                s_axis_tlast  <= w.last;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off counted down here
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: ends the run if no handshake of any kind happens for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("no handshake for %0d cycles, %0d reads still owed",
                 STALL_LIMIT, verdict_q.size());
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [7:0] any_of(input string set);
        return set[$urandom_range(set.len() - 1)];
    endfunction

    // 7-bit register value, sometimes with junk in the unused upper bits
    function automatic logic [15:0] noisy7(input int v);
        logic [15:0] r;
        r = 16'(v) & 16'h007F;
        if ($urandom_range(3) == 0)
            r[15:7] = 9'($urandom_range(511));
        return r;
    endfunction

    function automatic int draw_length();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return $urandom_range(8, 1);
        if (r < 95)
            return $urandom_range(40, 9);
        return $urandom_range(120, 41);
    endfunction

    task automatic push_word(input logic [7:0] b, input logic [7:0] q, input logic last);
        t_base_word w;
        w.base = b;
        w.qual = q;
        w.last = last;
        base_q = {base_q, w};
        bases_queued++;
    endtask

    // One read: GC share drawn per read, a few N bases, odd_pct percent of
    // arbitrary characters, mostly sane quality with some wild values.
    task automatic queue_read(input int len, input int odd_pct);
        int gc_pct, pick;
        logic [7:0] b, q;
        gc_pct = $urandom_range(100);
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(99);
            if (pick < odd_pct)
                b = 8'($urandom_range(255));
            else if (pick < odd_pct + 6)
                b = any_of("Nn");
            else if ($urandom_range(99) < gc_pct)
                b = any_of("GCgc");
            else
                b = any_of("ATat");
            if ($urandom_range(99) < 8)
                q = 8'($urandom_range(255));
            else
                q = 8'(int'(qual_offset_r) + $urandom_range(45, 3));
            push_word(b, q, i == len - 1);
        end
    endtask

    task automatic play_random(input int n_items);
        int target;
        target = bases_queued + n_items;
        while (bases_queued < target)
            queue_read(draw_length(), ($urandom_range(4) == 0) ? 5 : 0);
    endtask

    task automatic write_reg(input rqf_pkg::t_cfg_idx idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
    endtask

    task automatic write_plan();
        for (int i = 0; i < 8; i++)
            write_reg(rqf_pkg::t_cfg_idx'(i), plan[i]);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic default_plan();
        plan[rqf_pkg::CFG_QUAL_OFFSET]    = 16'd33;
        plan[rqf_pkg::CFG_MAX_N_COUNT]    = 16'hFFFF;
        plan[rqf_pkg::CFG_MIN_BASE_QUAL]  = 16'd0;
        plan[rqf_pkg::CFG_MIN_MEAN_QUAL]  = 16'd0;
        plan[rqf_pkg::CFG_MIN_LENGTH]     = 16'd0;
        plan[rqf_pkg::CFG_MAX_LENGTH]     = 16'hFFFF;
        plan[rqf_pkg::CFG_MIN_GC_PERCENT] = 16'd0;
        plan[rqf_pkg::CFG_MAX_GC_PERCENT] = 16'd100;
    endtask

    // thresholds near where typical reads sit, so both verdicts show up
    task automatic random_plan();
        if ($urandom_range(3) == 0)
            plan[rqf_pkg::CFG_QUAL_OFFSET] = noisy7($urandom_range(127));
        else
            plan[rqf_pkg::CFG_QUAL_OFFSET] = noisy7($urandom_range(1) ? 33 : 64);
        plan[rqf_pkg::CFG_MAX_N_COUNT] =
            $urandom_range(1) ? 16'($urandom_range(3)) : 16'hFFFF;
        plan[rqf_pkg::CFG_MIN_BASE_QUAL]  = noisy7($urandom_range(15));
        plan[rqf_pkg::CFG_MIN_MEAN_QUAL]  = noisy7($urandom_range(30));
        plan[rqf_pkg::CFG_MIN_LENGTH]     = 16'($urandom_range(12));
        plan[rqf_pkg::CFG_MAX_LENGTH] =
            $urandom_range(1) ? 16'($urandom_range(80, 8)) : 16'hFFFF;
        plan[rqf_pkg::CFG_MIN_GC_PERCENT] = noisy7($urandom_range(50));
        plan[rqf_pkg::CFG_MAX_GC_PERCENT] = noisy7($urandom_range(127, 50));
        write_plan();
    endtask

    // Sender pauses here until every queued base is taken and every owed verdict
    // is in, then idles before going on.
    task automatic settle();
        while (bases_accepted != bases_queued || verdict_q.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_pace(input int send_pct, input int recv_pct);
        @(posedge i_clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_pace(13, 68);

        // directed reads under the reset settings
        @(posedge i_clk);
        push_word("A", 8'h00, 1'b0);    // score far below zero
        push_word("C", 8'hFF, 1'b0);    // top quality char
        push_word("G", "I", 1'b0);
        push_word("T", "5", 1'b0);
        push_word("N", "#", 1'b0);
        push_word("a", "?", 1'b0);
        push_word("c", "+", 1'b0);
        push_word("g", "!", 1'b0);
        push_word("t", "(", 1'b0);
        push_word("n", "I", 1'b1);
        push_word(8'h00, 8'h00, 1'b1);  // all-zero word, odd base
        push_word(8'hFF, 8'hFF, 1'b1);  // all-ones word, odd base
        push_word("G", "I", 1'b1);      // GC exactly at the 100 percent bound
        push_word("A", "5", 1'b0);
        push_word("T", "5", 1'b1);
        push_word("N", "!", 1'b1);      // score exactly zero
        settle();

        // everything zero: zero offset, any N, any GC or any base fails
        foreach (plan[i])
            plan[i] = 16'd0;
        write_plan();
        @(posedge i_clk);
        play_random(100);
        settle();

        repeat (2) begin
            random_plan();
            @(posedge i_clk);
            play_random(100);
            settle();
        end

        set_pace(68, 13);
        repeat (2) begin
            random_plan();
            @(posedge i_clk);
            play_random(100);
            settle();
        end

        set_pace(0, 0);

        // receiver holds off while short reads keep coming, so finished
        // reads back up and the input stalls
        default_plan();
        write_plan();
        @(posedge i_clk);
        rx_hold = HOLD_CYCLES;
        while (bases_queued < bases_accepted + 60)
            queue_read($urandom_range(3, 1), 0);
        settle();

        // everything at its top value, 7-bit fields get junk upper bits
        foreach (plan[i])
            plan[i] = 16'hFFFF;
        write_plan();
        @(posedge i_clk);
        play_random(100);
        settle();

        random_plan();
        @(posedge i_clk);
        play_random(100);
        settle();

        $display("checked %0d reads from %0d bases over %0d register settings,",
                 reads_checked, bases_accepted, settings_used + 1);
        $display("with sender and receiver stalls and a long output hold-off; %0d mismatches",
                 fails);
        if (fails == 0 && verdict_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
